// File: hdl/ffpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffpa_pkg
// shared constants, codes and types for the first-fit page allocator
// ----------------------------------------------------------------------------
package ffpa_pkg;

    localparam int PAGE_BYTES   = 4096;   // power of two
    localparam int NUM_PAGES    = 2048;
    localparam int HEADER_BYTES = 32;

    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int PAGE_W     = $clog2(NUM_PAGES);   // page number
    localparam int CNT_W      = PAGE_W + 1;          // page count, holds NUM_PAGES
    localparam int P_W        = CNT_W + 1;           // walk pointer, holds p + count
    localparam int SIZE_W     = 24;
    localparam int SUM_W      = SIZE_W + 1;          // size plus header
    localparam int STATUS_W   = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ALLOC    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOROOM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FREED    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic             busy;
        logic [CNT_W-1:0] pages;
    } ffpa_entry_t;

    typedef enum logic [2:0] {
        FFA_IDLE,
        FFA_READ,
        FFA_EVAL,
        FFA_SPLIT,
        FFA_RESP
    } ffpa_state_t;

endpackage

// File: hdl/first_fit_page_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_page_allocator_core
// page-granular first-fit allocator with a walked block table
// ----------------------------------------------------------------------------
// Each request beat walks the block table from page 0 in address order, one
// block per visit. A visit is a table read (READ) followed by a compare
// (EVAL). The walk is set by the block table's one read port: one entry read
// and one compare per block. An allocate that splits a block also passes
// through SPLIT, which writes the remainder entry. in_ready is high only
// while the walker is idle; a finished result waits in the output register,
// and the next request beat may be taken while it waits. The block table is
// not cleared at reset; only entries at block starts are ever read, and each
// of those is written when its block is made. Adjacent free blocks are never
// merged.
// ----------------------------------------------------------------------------
module first_fit_page_allocator_core
    import ffpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // request channel
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                operation,
    input  logic [SIZE_W-1:0]   size_bytes,
    input  logic [PAGE_W-1:0]   page_index,
    // result channel
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [PAGE_W-1:0]   start_page,
    output logic [CNT_W-1:0]    pages_granted
);

    // sequencer state
    ffpa_state_t state_reg, state_next;

    // control registers
    logic [CNT_W-1:0] used_end_reg, used_end_next;   // first page past the last block
    logic             out_valid_reg, out_valid_next;

    // request context, latched on the accepted beat
    logic             op_reg, op_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [CNT_W-1:0] need_reg, need_next;
    logic [P_W-1:0]   p_reg, p_next;                 // walk pointer, also split page
    logic [CNT_W-1:0] split_cnt_reg, split_cnt_next;

    // pending result and output register
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [PAGE_W-1:0]   res_start_reg, res_start_next;
    logic [CNT_W-1:0]    res_cnt_reg, res_cnt_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [PAGE_W-1:0]   start_reg, start_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;

    // block table
    ffpa_entry_t      table_mem [NUM_PAGES];
    ffpa_entry_t      rd_reg;
    logic             mem_we;
    logic [PAGE_W-1:0] mem_waddr;
    ffpa_entry_t      mem_wdata;

    // shared compare datapath
    logic [SUM_W-1:0] size_sum;
    logic [SUM_W-1:0] need_full;
    logic             need_too_big;
    logic [CNT_W-1:0] step;           // stored count, zero stepped as one page
    logic [P_W-1:0]   blk_end;        // p + step
    logic [P_W-1:0]   split_at;       // p + need
    logic             in_region;      // p below used end
    logic             alloc_hit;
    logic             free_hit;
    logic             split_hit;
    logic [P_W-1:0]   append_end;
    logic             append_fits;
    logic             out_free;

    // need = (size + header) / page + 1
    assign size_sum     = {1'b0, size_bytes} + SUM_W'(HEADER_BYTES);
    assign need_full    = (size_sum >> PAGE_SHIFT) + SUM_W'(1);
    assign need_too_big = (need_full > SUM_W'(NUM_PAGES));

    assign step      = (rd_reg.pages == '0) ? CNT_W'(1) : rd_reg.pages;
    assign blk_end   = p_reg + P_W'(step);
    assign split_at  = p_reg + P_W'(need_reg);
    assign in_region = (p_reg < P_W'(used_end_reg));
    assign alloc_hit = !rd_reg.busy && (step >= need_reg);
    assign free_hit  = (P_W'(page_reg) >= p_reg) && (P_W'(page_reg) < blk_end);
    assign split_hit = (step > need_reg) && (split_at < P_W'(NUM_PAGES));

    assign append_end  = P_W'(used_end_reg) + P_W'(need_reg);
    assign append_fits = (append_end <= P_W'(NUM_PAGES));

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FFA_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_ALLOC && need_too_big)
                        state_next = FFA_RESP;
                    else
                        state_next = FFA_READ;
                end
            end
            FFA_READ:
            begin
                // table read is in flight when still inside the used region
                if (in_region)
                    state_next = FFA_EVAL;
                else
                    state_next = FFA_RESP;
            end
            FFA_EVAL:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (alloc_hit && split_hit)
                        state_next = FFA_SPLIT;
                    else if (alloc_hit)
                        state_next = FFA_RESP;
                    else
                        state_next = FFA_READ;
                end
                else
                begin
                    if (free_hit)
                        state_next = FFA_RESP;
                    else
                        state_next = FFA_READ;
                end
            end
            FFA_SPLIT:
            begin
                state_next = FFA_RESP;
            end
            FFA_RESP:
            begin
                if (out_free)
                    state_next = FFA_IDLE;
            end
            default:
            begin
                state_next = FFA_IDLE;
            end
        endcase
    end

    // datapath and table writes
    always_comb
    begin
        used_end_next   = used_end_reg;
        out_valid_next  = out_valid_reg;
        op_next         = op_reg;
        page_next       = page_reg;
        need_next       = need_reg;
        p_next          = p_reg;
        split_cnt_next  = split_cnt_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        res_cnt_next    = res_cnt_reg;
        status_next     = status_reg;
        start_next      = start_reg;
        cnt_next        = cnt_reg;
        mem_we          = 1'b0;
        mem_waddr       = p_reg[PAGE_W-1:0];
        mem_wdata       = '{busy: 1'b0, pages: '0};
        in_ready        = 1'b0;

        // result beat taken downstream
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            FFA_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op_next         = operation;
                    page_next       = page_index;
                    need_next       = need_full[CNT_W-1:0];
                    p_next          = '0;
                    res_status_next = ST_NOROOM;
                    res_start_next  = '0;
                    res_cnt_next    = '0;
                end
            end
            FFA_READ:
            begin
                if (!in_region)
                begin
                    res_start_next = '0;
                    res_cnt_next   = '0;
                    if (op_reg == OP_FREE)
                        res_status_next = ST_NOTFOUND;
                    else if (!append_fits)
                        res_status_next = ST_NOROOM;
                    else
                    begin
                        // append at the end of the used region
                        mem_we          = 1'b1;
                        mem_waddr       = used_end_reg[PAGE_W-1:0];
                        mem_wdata       = '{busy: 1'b1, pages: need_reg};
                        used_end_next   = append_end[CNT_W-1:0];
                        res_status_next = ST_ALLOC;
                        res_start_next  = used_end_reg[PAGE_W-1:0];
                        res_cnt_next    = need_reg;
                    end
                end
            end
            FFA_EVAL:
            begin
                if (op_reg == OP_ALLOC)
                begin
                    if (alloc_hit)
                    begin
                        mem_we          = 1'b1;
                        mem_wdata       = '{busy: 1'b1, pages: need_reg};
                        res_status_next = ST_ALLOC;
                        res_start_next  = p_reg[PAGE_W-1:0];
                        res_cnt_next    = need_reg;
                        // surplus becomes a free block right after the grant
                        p_next          = split_at;
                        split_cnt_next  = step - need_reg;
                    end
                    else
                        p_next = blk_end;
                end
                else
                begin
                    if (free_hit)
                    begin
                        mem_we          = 1'b1;
                        mem_wdata       = '{busy: 1'b0, pages: rd_reg.pages};
                        res_status_next = ST_FREED;
                        res_start_next  = '0;
                        res_cnt_next    = '0;
                    end
                    else
                        p_next = blk_end;
                end
            end
            FFA_SPLIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{busy: 1'b0, pages: split_cnt_reg};
            end
            FFA_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    start_next     = res_start_reg;
                    cnt_next       = res_cnt_reg;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FFA_IDLE;
            used_end_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_end_reg  <= used_end_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        page_reg       <= page_next;
        need_reg       <= need_next;
        p_reg          <= p_next;
        split_cnt_reg  <= split_cnt_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        res_cnt_reg    <= res_cnt_next;
        status_reg     <= status_next;
        start_reg      <= start_next;
        cnt_reg        <= cnt_next;
    end

    // block table: one write port, one registered read at the walk pointer
    always_ff @(posedge clk)
    begin
        if (mem_we)
            table_mem[mem_waddr] <= mem_wdata;
        rd_reg <= table_mem[p_reg[PAGE_W-1:0]];
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign start_page    = start_reg;
    assign pages_granted = cnt_reg;

endmodule
